FILE: rtl/trrag_pkg.sv
// Package for the tiled row-repeat address generator.
// Holds field widths, tile geometry, register indexes, divider handshake types
// and the face-ordered index function. No dependencies.
`timescale 1ns / 1ps

package trrag_pkg;

  localparam int TILE_ID_W = 24;
  localparam int POS_W     = 5;
  localparam int IDX_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int ROWCOL_W  = 17;
  localparam int REPEAT_W  = 8;
  localparam int TCOUNT_W  = 12;

  localparam int TILE_LOG2 = 5;
  localparam int FACE_LOG2 = 4;
  localparam int TILE_SIDE = 1 << TILE_LOG2;
  localparam int FACE_SIDE = 1 << FACE_LOG2;
  localparam int FACES_ACROSS = TILE_SIDE / FACE_SIDE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_ROWS      = 3'd0,
    CFG_COLUMNS       = 3'd1,
    CFG_REPEAT        = 3'd2,
    CFG_IN_TILE_ROWS  = 3'd3,
    CFG_IN_TILES_ROW  = 3'd4,
    CFG_OUT_TILE_ROWS = 3'd5,
    CFG_OUT_TILES_ROW = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [TILE_ID_W-1:0] dividend;
    logic [TILE_ID_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TILE_ID_W-1:0] quotient;
    logic [TILE_ID_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [IDX_W-1:0] face_idx(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
    logic [31:0] fr;
    logic [31:0] fc;
    logic [31:0] idx;
    fr  = 32'(r) >> FACE_LOG2;
    fc  = 32'(c) >> FACE_LOG2;
    idx = ((fr * 32'(FACES_ACROSS) + fc) << (2 * FACE_LOG2))
        + ((32'(r) & 32'(FACE_SIDE - 1)) << FACE_LOG2)
        + (32'(c) & 32'(FACE_SIDE - 1));
    return idx[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/tiled_row_repeat_address_gen.sv
// Top level of the tiled row-repeat address generator.
// Depends on trrag_pkg and the serial divider trrag_div.
// An item is taken only in the idle state, so no new item is taken until the result of the last one
// has been placed in the output register; an output stall holds the result, and the next item, back.
// The shared serial divider gives one quotient bit per cycle over two 24-bit divisions, and a
// third for an element inside the extent; a shared 24x12 multiplier is combinational and its product is registered.
// Reset is asynchronous and active low; it loads register defaults and drops the held tile.
`timescale 1ns / 1ps

module tiled_row_repeat_address_gen
  import trrag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TILE_ID_W-1:0]  out_tile_id_i,
  input  logic [POS_W-1:0]      row_in_tile_i,
  input  logic [POS_W-1:0]      col_in_tile_i,
  input  logic                  first_of_tile_i,
  input  logic                  last_of_tile_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  in_extent_o,
  output logic [TILE_ID_W-1:0]  src_tile_id_o,
  output logic [IDX_W-1:0]      src_elem_index_o,
  output logic [IDX_W-1:0]      dst_elem_index_o,
  output logic                  fetch_tile_o,
  output logic                  release_before_o,
  output logic                  release_after_o
);

  localparam int RowW  = TILE_ID_W + TILE_LOG2;
  localparam int ProdW = TILE_ID_W + TCOUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAT,
    S_DIV_BATCH,
    S_WAIT_BATCH,
    S_DIV_TILE,
    S_WAIT_TILE,
    S_EXTENT,
    S_DIV_ROW,
    S_WAIT_ROW,
    S_MUL_BATCH,
    S_MUL_ROW,
    S_FINISH
  } state_e;

  logic [ROWCOL_W-1:0] orc_q;
  logic [ROWCOL_W-1:0] cc_q;
  logic [REPEAT_W-1:0] rep_q;
  logic [TCOUNT_W-1:0] itr_q;
  logic [TCOUNT_W-1:0] itpr_q;
  logic [TCOUNT_W-1:0] otr_q;
  logic [TCOUNT_W-1:0] otpr_q;

  state_e               state_q;
  logic [TILE_ID_W-1:0] tile_id_q;
  logic [POS_W-1:0]     r_q;
  logic [POS_W-1:0]     c_q;
  logic                 first_q;
  logic                 last_q;
  logic [TILE_ID_W-1:0] mat_q;
  logic [TILE_ID_W-1:0] batch_q;
  logic [TILE_ID_W-1:0] in_mat_q;
  logic [TILE_ID_W-1:0] tile_row_q;
  logic [TILE_ID_W-1:0] tile_col_q;
  logic [TILE_ID_W-1:0] irow_q;
  logic [TILE_ID_W-1:0] acc_q;
  logic                 extent_q;
  logic [TILE_ID_W-1:0] held_tile_q;
  logic                 held_valid_q;
  logic                 out_valid_q;

  logic [TCOUNT_W-1:0]  otr_nz;
  logic [TCOUNT_W-1:0]  otpr_nz;
  logic [REPEAT_W-1:0]  rep_nz;
  logic [TILE_ID_W-1:0] mul_a;
  logic [TCOUNT_W-1:0]  mul_b;
  logic [ProdW-1:0]     prod;
  logic [RowW-1:0]      orow;
  logic [RowW-1:0]      ocol;
  logic                 in_tile;
  logic                 extent;
  logic [TILE_ID_W-1:0] src_tile;
  logic                 hv_first;
  logic                 fetch;
  logic                 rel_before;
  logic                 hv_mid;
  logic                 out_free;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign otr_nz  = (otr_q == '0) ? TCOUNT_W'(1) : otr_q;
  assign otpr_nz = (otpr_q == '0) ? TCOUNT_W'(1) : otpr_q;
  assign rep_nz  = (rep_q == '0) ? REPEAT_W'(1) : rep_q;

  always_comb begin
    case (state_q)
      S_MAT: begin
        mul_a = TILE_ID_W'(otr_nz);
        mul_b = otpr_nz;
      end
      S_MUL_BATCH: begin
        mul_a = batch_q;
        mul_b = itr_q;
      end
      default: begin
        mul_a = acc_q;
        mul_b = itpr_q;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    div_req = '0;
    case (state_q)
      S_DIV_BATCH: begin
        div_req.start    = 1'b1;
        div_req.dividend = tile_id_q;
        div_req.divisor  = mat_q;
      end
      S_DIV_TILE: begin
        div_req.start    = 1'b1;
        div_req.dividend = in_mat_q;
        div_req.divisor  = TILE_ID_W'(otpr_nz);
      end
      S_DIV_ROW: begin
        div_req.start    = 1'b1;
        div_req.dividend = orow[TILE_ID_W-1:0];
        div_req.divisor  = TILE_ID_W'(rep_nz);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  trrag_div #(
    .Width(TILE_ID_W)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign orow    = {tile_row_q, TILE_LOG2'(0)} + RowW'(r_q);
  assign ocol    = {tile_col_q, TILE_LOG2'(0)} + RowW'(c_q);
  assign in_tile = (32'(r_q) < 32'(TILE_SIDE)) && (32'(c_q) < 32'(TILE_SIDE));
  assign extent  = in_tile && (orow < RowW'(orc_q)) && (ocol < RowW'(cc_q));

  assign src_tile   = acc_q;
  assign hv_first   = first_q ? 1'b0 : held_valid_q;
  assign fetch      = extent_q && (!hv_first || (held_tile_q != src_tile));
  assign rel_before = fetch && hv_first;
  assign hv_mid     = hv_first || extent_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orc_q  <= ROWCOL_W'(32);
      cc_q   <= ROWCOL_W'(32);
      rep_q  <= REPEAT_W'(1);
      itr_q  <= TCOUNT_W'(1);
      itpr_q <= TCOUNT_W'(1);
      otr_q  <= TCOUNT_W'(1);
      otpr_q <= TCOUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OUT_ROWS:      orc_q  <= cfg_data_i[ROWCOL_W-1:0];
        CFG_COLUMNS:       cc_q   <= cfg_data_i[ROWCOL_W-1:0];
        CFG_REPEAT:        rep_q  <= cfg_data_i[REPEAT_W-1:0];
        CFG_IN_TILE_ROWS:  itr_q  <= cfg_data_i[TCOUNT_W-1:0];
        CFG_IN_TILES_ROW:  itpr_q <= cfg_data_i[TCOUNT_W-1:0];
        CFG_OUT_TILE_ROWS: otr_q  <= cfg_data_i[TCOUNT_W-1:0];
        CFG_OUT_TILES_ROW: otpr_q <= cfg_data_i[TCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      held_valid_q <= 1'b0;
      held_tile_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tile_id_q <= out_tile_id_i;
            r_q       <= row_in_tile_i;
            c_q       <= col_in_tile_i;
            first_q   <= first_of_tile_i;
            last_q    <= last_of_tile_i;
            state_q   <= S_MAT;
          end
        end
        S_MAT: begin
          mat_q   <= prod[TILE_ID_W-1:0];
          state_q <= S_DIV_BATCH;
        end
        S_DIV_BATCH: state_q <= S_WAIT_BATCH;
        S_WAIT_BATCH: begin
          if (div_rsp.done) begin
            batch_q  <= div_rsp.quotient;
            in_mat_q <= div_rsp.remainder;
            state_q  <= S_DIV_TILE;
          end
        end
        S_DIV_TILE: state_q <= S_WAIT_TILE;
        S_WAIT_TILE: begin
          if (div_rsp.done) begin
            tile_row_q <= div_rsp.quotient;
            tile_col_q <= div_rsp.remainder;
            state_q    <= S_EXTENT;
          end
        end
        S_EXTENT: begin
          extent_q <= extent;
          acc_q    <= '0;
          state_q  <= extent ? S_DIV_ROW : S_FINISH;
        end
        S_DIV_ROW: state_q <= S_WAIT_ROW;
        S_WAIT_ROW: begin
          if (div_rsp.done) begin
            irow_q  <= div_rsp.quotient;
            state_q <= S_MUL_BATCH;
          end
        end
        S_MUL_BATCH: begin
          acc_q   <= prod[TILE_ID_W-1:0] + TILE_ID_W'(irow_q >> TILE_LOG2);
          state_q <= S_MUL_ROW;
        end
        S_MUL_ROW: begin
          acc_q   <= prod[TILE_ID_W-1:0] + tile_col_q;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            in_extent_o      <= extent_q;
            src_tile_id_o    <= extent_q ? src_tile : '0;
            src_elem_index_o <= extent_q ? face_idx(irow_q[TILE_LOG2-1:0], c_q) : '0;
            dst_elem_index_o <= in_tile ? face_idx(r_q, c_q) : '0;
            fetch_tile_o     <= fetch;
            release_before_o <= rel_before;
            release_after_o  <= last_q && hv_mid;
            held_valid_q     <= last_q ? 1'b0 : hv_mid;
            if (fetch) begin
              held_tile_q <= src_tile;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in work");
  a_release_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_before_o |-> fetch_tile_o)
    else $error("release before without a fetch");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_extent_o |-> !fetch_tile_o && src_tile_id_o == '0
                                    && src_elem_index_o == '0)
    else $error("outside element carries source data");
  a_held_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && out_free && fetch && !last_q
      |=> held_valid_q && held_tile_q == src_tile_id_o)
    else $error("held tile not updated on fetch");
`endif

endmodule

FILE: rtl/trrag_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Uses the request and response types of trrag_pkg. The divisor must be nonzero.
`timescale 1ns / 1ps

module trrag_div
  import trrag_pkg::*;
#(
  parameter int Width = TILE_ID_W
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q;
  logic [Width-1:0] quo_q;
  logic [Width-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend[Width-1:0];
      dvs_q <= req_i.divisor[Width-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? diff[Width-1:0] : shifted[Width-1:0];
      quo_q <= {quo_q[Width-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = TILE_ID_W'(quo_q);
  assign rsp_o.remainder = TILE_ID_W'(rem_q);

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");
`endif

endmodule
